// ===== hdl/hprs_pkg.sv =====
package hprs_pkg;

  // Address and frame geometry.
  localparam int ADDR_W      = 52;
  localparam int FRAME_SHIFT = 12;
  localparam int FRAME_W     = ADDR_W - FRAME_SHIFT;
  // One spare bit so that rounding up at the top of the space cannot wrap.
  localparam int FRAME_XW    = FRAME_W + 1;
  // 2 MiB and 1 GiB alignment, in 4 KiB frames, as shifts.
  localparam int MID_SHIFT   = 9;
  localparam int BIG_SHIFT   = 18;

  localparam int MAX_SEGMENTS = 5;
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int MASK_W       = 2;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Candidate segment slots, in address order.
  localparam int SEG_HEAD4K = 0;
  localparam int SEG_PART2M = 1;
  localparam int SEG_MID1G  = 2;
  localparam int SEG_TAIL2M = 3;
  localparam int SEG_TAIL4K = 4;

  // Page size mask bits.
  localparam logic [MASK_W-1:0] MASK_4K_ONLY = 2'b00;
  localparam logic [MASK_W-1:0] MASK_2M      = 2'b01;

  typedef logic [FRAME_W-1:0]  frame_t;
  typedef logic [FRAME_XW-1:0] frame_x_t;
  typedef logic [MASK_W-1:0]   page_mask_t;

  typedef struct packed {
    frame_t     first;
    frame_t     past;
    page_mask_t mask;
  } seg_t;

  // One queue entry: the merged segments of one range and their count.
  typedef struct packed {
    seg_t [MAX_SEGMENTS-1:0] seg;
    logic [CNT_W-1:0]        cnt;
  } seg_list_t;

endpackage

// ===== hdl/hprs_front.sv =====
module hprs_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [hprs_pkg::ADDR_W-1:0]    in_range_start,
  input  logic [hprs_pkg::ADDR_W-1:0]    in_range_end,
  input  hprs_pkg::page_mask_t           page_size_enable,
  output logic                           q_push,
  input  logic                           q_full,
  output hprs_pkg::seg_list_t            q_data
);

  // Round a frame number up to a 2 MiB boundary.
  function automatic hprs_pkg::frame_x_t up_mid(input hprs_pkg::frame_x_t v);
    logic [hprs_pkg::FRAME_XW-hprs_pkg::MID_SHIFT-1:0] hi;
    hi = v[hprs_pkg::FRAME_XW-1:hprs_pkg::MID_SHIFT]
         + {{(hprs_pkg::FRAME_XW-hprs_pkg::MID_SHIFT-1){1'b0}},
            |v[hprs_pkg::MID_SHIFT-1:0]};
    return {hi, {hprs_pkg::MID_SHIFT{1'b0}}};
  endfunction

  // Round a frame number up to a 1 GiB boundary.
  function automatic hprs_pkg::frame_x_t up_big(input hprs_pkg::frame_x_t v);
    logic [hprs_pkg::FRAME_XW-hprs_pkg::BIG_SHIFT-1:0] hi;
    hi = v[hprs_pkg::FRAME_XW-1:hprs_pkg::BIG_SHIFT]
         + {{(hprs_pkg::FRAME_XW-hprs_pkg::BIG_SHIFT-1){1'b0}},
            |v[hprs_pkg::BIG_SHIFT-1:0]};
    return {hi, {hprs_pkg::BIG_SHIFT{1'b0}}};
  endfunction

  // Stage valid flags and the pipeline advance chain.
  logic s1_v_r, s2_v_r, s3_v_r;
  logic adv1, adv2, adv3;

  assign adv3    = !s3_v_r || !q_full;
  assign adv2    = !s2_v_r || adv3;
  assign adv1    = !s1_v_r || adv2;
  assign in_full = !adv1;
  assign q_push  = s3_v_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r <= in_push;
      if (adv2) s2_v_r <= s1_v_r;
      if (adv3) s3_v_r <= s2_v_r;
    end
  end

  // Stage 1: truncate to frames and derive the alignment points.
  hprs_pkg::frame_x_t a_in, l_in;
  hprs_pkg::frame_x_t a1_r, l1_r, u1_r, g1_r, ld1_r, lg1_r;

  assign a_in = {1'b0, in_range_start[hprs_pkg::ADDR_W-1:hprs_pkg::FRAME_SHIFT]};
  assign l_in = {1'b0, in_range_end[hprs_pkg::ADDR_W-1:hprs_pkg::FRAME_SHIFT]};

  always_ff @(posedge clk) begin
    if (adv1) begin
      a1_r  <= a_in;
      l1_r  <= l_in;
      u1_r  <= up_mid(a_in);
      g1_r  <= up_big(a_in);
      ld1_r <= {l_in[hprs_pkg::FRAME_XW-1:hprs_pkg::MID_SHIFT],
                {hprs_pkg::MID_SHIFT{1'b0}}};
      lg1_r <= {l_in[hprs_pkg::FRAME_XW-1:hprs_pkg::BIG_SHIFT],
                {hprs_pkg::BIG_SHIFT{1'b0}}};
    end
  end

  // Stage 2: head, 2 MiB part and 1 GiB middle; start of the 2 MiB tail.
  logic               v1, v2, v3;
  hprs_pkg::frame_x_t e1, e2, cur1, s4, cur3;

  always_comb begin
    v1   = (a1_r < u1_r) && (a1_r < l1_r);
    e1   = (u1_r < l1_r) ? u1_r : l1_r;
    cur1 = v1 ? e1 : a1_r;
    v2   = (u1_r < g1_r) && (u1_r < ld1_r);
    e2   = (g1_r < ld1_r) ? g1_r : ld1_r;
    v3   = g1_r < lg1_r;
    s4   = v3 ? lg1_r : (v2 ? e2 : u1_r);
    cur3 = v3 ? lg1_r : (v2 ? e2 : cur1);
  end

  logic               v1_2_r, v2_2_r, v3_2_r;
  hprs_pkg::frame_x_t a2_r, e1_2_r, u2_r, e2_2_r, g2_r, lg2_r, ld2_r, l2_r;
  hprs_pkg::frame_x_t s4_2_r, cur3_2_r;

  always_ff @(posedge clk) begin
    if (adv2) begin
      v1_2_r   <= v1;
      v2_2_r   <= v2;
      v3_2_r   <= v3;
      a2_r     <= a1_r;
      e1_2_r   <= e1;
      u2_r     <= u1_r;
      e2_2_r   <= e2;
      g2_r     <= g1_r;
      lg2_r    <= lg1_r;
      ld2_r    <= ld1_r;
      l2_r     <= l1_r;
      s4_2_r   <= s4;
      cur3_2_r <= cur3;
    end
  end

  // Stage 3: 2 MiB tail and 4 KiB tail; collect the five candidates.
  logic               v4, v5;
  hprs_pkg::frame_x_t cur4;

  always_comb begin
    v4   = s4_2_r < ld2_r;
    cur4 = v4 ? ld2_r : cur3_2_r;
    v5   = cur4 < l2_r;
  end

  logic [hprs_pkg::MAX_SEGMENTS-1:0] cand_v_r;
  hprs_pkg::frame_t                  cand_first_r [hprs_pkg::MAX_SEGMENTS];
  hprs_pkg::frame_t                  cand_past_r  [hprs_pkg::MAX_SEGMENTS];

  always_ff @(posedge clk) begin
    if (adv3) begin
      cand_v_r[hprs_pkg::SEG_HEAD4K]     <= v1_2_r;
      cand_v_r[hprs_pkg::SEG_PART2M]     <= v2_2_r;
      cand_v_r[hprs_pkg::SEG_MID1G]      <= v3_2_r;
      cand_v_r[hprs_pkg::SEG_TAIL2M]     <= v4;
      cand_v_r[hprs_pkg::SEG_TAIL4K]     <= v5;
      cand_first_r[hprs_pkg::SEG_HEAD4K] <= a2_r[hprs_pkg::FRAME_W-1:0];
      cand_past_r[hprs_pkg::SEG_HEAD4K]  <= e1_2_r[hprs_pkg::FRAME_W-1:0];
      cand_first_r[hprs_pkg::SEG_PART2M] <= u2_r[hprs_pkg::FRAME_W-1:0];
      cand_past_r[hprs_pkg::SEG_PART2M]  <= e2_2_r[hprs_pkg::FRAME_W-1:0];
      cand_first_r[hprs_pkg::SEG_MID1G]  <= g2_r[hprs_pkg::FRAME_W-1:0];
      cand_past_r[hprs_pkg::SEG_MID1G]   <= lg2_r[hprs_pkg::FRAME_W-1:0];
      cand_first_r[hprs_pkg::SEG_TAIL2M] <= s4_2_r[hprs_pkg::FRAME_W-1:0];
      cand_past_r[hprs_pkg::SEG_TAIL2M]  <= ld2_r[hprs_pkg::FRAME_W-1:0];
      cand_first_r[hprs_pkg::SEG_TAIL4K] <= cur4[hprs_pkg::FRAME_W-1:0];
      cand_past_r[hprs_pkg::SEG_TAIL4K]  <= l2_r[hprs_pkg::FRAME_W-1:0];
    end
  end

  // Masks of the candidate slots: the 4 KiB slots are fixed, the others are taken from the enable register.
  hprs_pkg::page_mask_t cand_mask [hprs_pkg::MAX_SEGMENTS];

  always_comb begin
    cand_mask[hprs_pkg::SEG_HEAD4K] = hprs_pkg::MASK_4K_ONLY;
    cand_mask[hprs_pkg::SEG_PART2M] = page_size_enable & hprs_pkg::MASK_2M;
    cand_mask[hprs_pkg::SEG_MID1G]  = page_size_enable;
    cand_mask[hprs_pkg::SEG_TAIL2M] = page_size_enable & hprs_pkg::MASK_2M;
    cand_mask[hprs_pkg::SEG_TAIL4K] = hprs_pkg::MASK_4K_ONLY;
  end

  // Drop empty candidates and merge neighbours with equal masks. The
  // candidates always touch, so only the masks need comparing.
  logic [hprs_pkg::CNT_W-1:0] k;
  logic [hprs_pkg::CNT_W-1:0] km1;
  hprs_pkg::page_mask_t       prev_mask;
  logic                       seen;

  always_comb begin
    q_data    = '0;
    k         = '0;
    km1       = '0;
    prev_mask = hprs_pkg::MASK_4K_ONLY;
    seen      = 1'b0;
    for (int i = 0; i < hprs_pkg::MAX_SEGMENTS; i++) begin
      if (cand_v_r[i]) begin
        if (!seen || (cand_mask[i] != prev_mask)) begin
          q_data.seg[k[hprs_pkg::IDX_W-1:0]].first = cand_first_r[i];
          q_data.seg[k[hprs_pkg::IDX_W-1:0]].past  = cand_past_r[i];
          q_data.seg[k[hprs_pkg::IDX_W-1:0]].mask  = cand_mask[i];
          k = k + hprs_pkg::CNT_W'(1);
        end else begin
          km1 = k - hprs_pkg::CNT_W'(1);
          q_data.seg[km1[hprs_pkg::IDX_W-1:0]].past = cand_past_r[i];
        end
        prev_mask = cand_mask[i];
        seen      = 1'b1;
      end
    end
    q_data.cnt = k;
  end

endmodule

// ===== hdl/hprs_queue.sv =====
module hprs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  hprs_pkg::seg_list_t wdata,
  input  logic                pop,
  output logic                empty,
  output hprs_pkg::seg_list_t rdata
);

  hprs_pkg::seg_list_t         mem_r [hprs_pkg::QUEUE_DEPTH];
  logic [hprs_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [hprs_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [hprs_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                        do_push, do_pop;

  assign full    = cnt_r == hprs_pkg::QCNT_W'(hprs_pkg::QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + hprs_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + hprs_pkg::QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + hprs_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - hprs_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

// ===== hdl/hprs_back.sv =====
module hprs_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  hprs_pkg::seg_list_t         q_data,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [hprs_pkg::ADDR_W-1:0] out_seg_start,
  output logic [hprs_pkg::ADDR_W-1:0] out_seg_end,
  output hprs_pkg::page_mask_t        out_seg_page_mask,
  output logic                        out_seg_empty,
  output logic                        out_seg_last
);

  logic [hprs_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                       out_v_r, out_v_nxt;
  hprs_pkg::frame_t           start_r, end_r;
  hprs_pkg::page_mask_t       mask_r;
  logic                       empty_r, last_r;

  hprs_pkg::seg_t             cur_seg;
  logic                       is_empty, is_last, ld;

  // Pick the next segment of the queue head and decide whether it ends it.
  always_comb begin
    cur_seg  = q_data.seg[idx_r];
    is_empty = q_data.cnt == '0;
    is_last  = is_empty
               || (hprs_pkg::CNT_W'(idx_r) == q_data.cnt - hprs_pkg::CNT_W'(1));
    ld       = !q_empty && (!out_v_r || out_pop);
    q_pop    = ld && is_last;
    idx_nxt  = idx_r;
    if (ld) begin
      idx_nxt = is_last ? '0 : idx_r + hprs_pkg::IDX_W'(1);
    end
    out_v_nxt = ld || (out_v_r && !out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Result register: holds one beat until it is taken.
  always_ff @(posedge clk) begin
    if (ld) begin
      if (is_empty) begin
        start_r <= '0;
        end_r   <= '0;
        mask_r  <= hprs_pkg::MASK_4K_ONLY;
        empty_r <= 1'b1;
      end else begin
        start_r <= cur_seg.first;
        end_r   <= cur_seg.past;
        mask_r  <= cur_seg.mask;
        empty_r <= 1'b0;
      end
      last_r <= is_last;
    end
  end

  assign out_empty         = !out_v_r;
  assign out_seg_start     = {start_r, {hprs_pkg::FRAME_SHIFT{1'b0}}};
  assign out_seg_end       = {end_r, {hprs_pkg::FRAME_SHIFT{1'b0}}};
  assign out_seg_page_mask = mask_r;
  assign out_seg_empty     = empty_r;
  assign out_seg_last      = last_r;

endmodule

// ===== hdl/huge_page_range_splitter.sv =====
// A range passes through the three front stages, the queue and the result register on
// its way to the result ports. Throughput: one range per cycle enters while in_full
// is low; the back part gives one result beat per cycle while the queue is not empty
// and out_pop is high, and a range gives one to five result beats.
// Reset (rst_n low, synchronous) empties the pipeline and queue and clears the
// page size enable register to zero.
module huge_page_range_splitter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [hprs_pkg::ADDR_W-1:0] in_range_start,
  input  logic [hprs_pkg::ADDR_W-1:0] in_range_end,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [hprs_pkg::ADDR_W-1:0] out_seg_start,
  output logic [hprs_pkg::ADDR_W-1:0] out_seg_end,
  output logic [hprs_pkg::MASK_W-1:0] out_seg_page_mask,
  output logic                        out_seg_empty,
  output logic                        out_seg_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hprs_pkg::MASK_W-1:0] cfg_page_size_enable
);

  // Configuration register; a write is always taken.
  hprs_pkg::page_mask_t page_size_enable_r, page_size_enable_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    page_size_enable_nxt = page_size_enable_r;
    if (cfg_valid && cfg_ready) page_size_enable_nxt = cfg_page_size_enable;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_size_enable_r <= hprs_pkg::MASK_4K_ONLY;
    end else begin
      page_size_enable_r <= page_size_enable_nxt;
    end
  end

  // Front part, queue and back part.
  logic                q_push, q_full, q_pop, q_empty;
  hprs_pkg::seg_list_t q_wdata, q_rdata;

  hprs_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_range_start   (in_range_start),
    .in_range_end     (in_range_end),
    .page_size_enable (page_size_enable_r),
    .q_push           (q_push),
    .q_full           (q_full),
    .q_data           (q_wdata)
  );

  hprs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  hprs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .q_data            (q_rdata),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_seg_start     (out_seg_start),
    .out_seg_end       (out_seg_end),
    .out_seg_page_mask (out_seg_page_mask),
    .out_seg_empty     (out_seg_empty),
    .out_seg_last      (out_seg_last)
  );

endmodule

// ===== dv/huge_page_range_splitter_tb.sv =====
module huge_page_range_splitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hprs_pkg::*;

  // Byte sizes and the top of the 52-bit address space, kept 64 bits wide.
  localparam logic [63:0] TOP_ADDR = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] SZ_4K    = 64'h0000_1000;
  localparam logic [63:0] SZ_2M    = 64'h0020_0000;
  localparam logic [63:0] SZ_1G    = 64'h4000_0000;

  // Settings of the page size enable register.
  localparam page_mask_t EN_NONE = MASK_4K_ONLY;
  localparam page_mask_t EN_2M   = MASK_2M;
  localparam page_mask_t EN_1G   = 2'b10;
  localparam page_mask_t EN_BOTH = 2'b11;

  // A range that yields all five candidate segments before merging.
  localparam logic [63:0] FIVE_BASE  = 3 * SZ_1G - 5 * SZ_2M - 3 * SZ_4K + 64'h123;
  localparam logic [63:0] FIVE_LIMIT = 7 * SZ_1G + 3 * SZ_2M + 5 * SZ_4K + 64'hABC;

  localparam int HOLD_CYCLES   = 200;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_RANGES  = 38;

  typedef struct {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] limit;
  } range_t;

  typedef struct {
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] past;
    page_mask_t        mask;
    logic              empty;
    logic              last;
  } seg_rec_t;

  logic              clk;
  logic              rst_n                = 1'b0;
  logic              in_push              = 1'b0;
  logic              in_full;
  logic [ADDR_W-1:0] in_range_start       = '0;
  logic [ADDR_W-1:0] in_range_end         = '0;
  logic              out_empty;
  logic              out_pop              = 1'b0;
  logic [ADDR_W-1:0] out_seg_start;
  logic [ADDR_W-1:0] out_seg_end;
  page_mask_t        out_seg_page_mask;
  logic              out_seg_empty;
  logic              out_seg_last;
  logic              cfg_valid            = 1'b0;
  logic              cfg_ready;
  page_mask_t        cfg_page_size_enable = '0;

  range_t     ranges_to_send [$];
  seg_rec_t   segs_due [$];
  page_mask_t page_size_en = EN_NONE;

  bit in_beat, out_beat;
  bit tx_calm, rx_calm, hold_req;
  int tx_wait, rx_wait, hold_left;

  int err_count, ranges_taken, empty_ranges, segs_checked, full_cycles, cfg_writes;
  int seg_count_hist [1:MAX_SEGMENTS];

  huge_page_range_splitter dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_range_start       (in_range_start),
    .in_range_end         (in_range_end),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_seg_start        (out_seg_start),
    .out_seg_end          (out_seg_end),
    .out_seg_page_mask    (out_seg_page_mask),
    .out_seg_empty        (out_seg_empty),
    .out_seg_last         (out_seg_last),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_page_size_enable (cfg_page_size_enable)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Frame number rounding to a power-of-two alignment.
  function automatic logic [63:0] frame_up(logic [63:0] v, int sh);
    return ((v + (64'd1 << sh) - 64'd1) >> sh) << sh;
  endfunction

  function automatic logic [63:0] frame_down(logic [63:0] v, int sh);
    return (v >> sh) << sh;
  endfunction

  // Splits one accepted range into its segments and queues them as expected beats.
  function automatic void split_range(logic [ADDR_W-1:0] rs, logic [ADDR_W-1:0] re,
                                      page_mask_t en);
    logic [63:0] cs [MAX_SEGMENTS];
    logic [63:0] ce [MAX_SEGMENTS];
    page_mask_t  cm [MAX_SEGMENTS];
    logic [63:0] fst [MAX_SEGMENTS];
    logic [63:0] pst [MAX_SEGMENTS];
    page_mask_t  msk [MAX_SEGMENTS];
    logic [63:0] cur, lim, e;
    seg_rec_t    rec;
    int          n, k;
    lim = 64'(re) >> FRAME_SHIFT;
    cur = 64'(rs) >> FRAME_SHIFT;

    // 4 KiB head up to the next 2 MiB boundary, clipped to the end.
    e = frame_up(cur, MID_SHIFT);
    cs[SEG_HEAD4K] = cur;
    ce[SEG_HEAD4K] = (e > lim) ? lim : e;
    cm[SEG_HEAD4K] = MASK_4K_ONLY;
    if (cs[SEG_HEAD4K] < ce[SEG_HEAD4K]) cur = ce[SEG_HEAD4K];

    // 2 MiB part up to the next 1 GiB boundary, clipped to the last 2 MiB boundary.
    e = frame_up(cur, BIG_SHIFT);
    cs[SEG_PART2M] = frame_up(cur, MID_SHIFT);
    ce[SEG_PART2M] = (e > frame_down(lim, MID_SHIFT)) ? frame_down(lim, MID_SHIFT) : e;
    cm[SEG_PART2M] = en & MASK_2M;
    if (cs[SEG_PART2M] < ce[SEG_PART2M]) cur = ce[SEG_PART2M];

    // 1 GiB middle.
    cs[SEG_MID1G] = frame_up(cur, BIG_SHIFT);
    ce[SEG_MID1G] = frame_down(lim, BIG_SHIFT);
    cm[SEG_MID1G] = en;
    if (cs[SEG_MID1G] < ce[SEG_MID1G]) cur = ce[SEG_MID1G];

    // 2 MiB tail.
    cs[SEG_TAIL2M] = frame_up(cur, MID_SHIFT);
    ce[SEG_TAIL2M] = frame_down(lim, MID_SHIFT);
    cm[SEG_TAIL2M] = en & MASK_2M;
    if (cs[SEG_TAIL2M] < ce[SEG_TAIL2M]) cur = ce[SEG_TAIL2M];

    // 4 KiB tail.
    cs[SEG_TAIL4K] = cur;
    ce[SEG_TAIL4K] = lim;
    cm[SEG_TAIL4K] = MASK_4K_ONLY;

    // Drop empty candidates and fold each into its neighbour when they touch
    // and share a mask; merging left to right in one pass is enough.
    n = 0;
    for (k = 0; k < MAX_SEGMENTS; k++) begin
      if (cs[k] < ce[k]) begin
        if (n > 0 && pst[n-1] == cs[k] && msk[n-1] == cm[k]) begin
          pst[n-1] = ce[k];
        end else begin
          fst[n] = cs[k];
          pst[n] = ce[k];
          msk[n] = cm[k];
          n++;
        end
      end
    end

    if (n == 0) begin
      rec.first = '0;
      rec.past  = '0;
      rec.mask  = MASK_4K_ONLY;
      rec.empty = 1'b1;
      rec.last  = 1'b1;
      segs_due.push_back(rec);
      empty_ranges++;
    end else begin
      for (k = 0; k < n; k++) begin
        rec.first = ADDR_W'(fst[k] << FRAME_SHIFT);
        rec.past  = ADDR_W'(pst[k] << FRAME_SHIFT);
        rec.mask  = msk[k];
        rec.empty = 1'b0;
        rec.last  = (k == n - 1);
        segs_due.push_back(rec);
      end
      seg_count_hist[n]++;
    end
  endfunction

  function automatic logic [63:0] rand_addr();
    return {$urandom, $urandom} & TOP_ADDR;
  endfunction

  // Zero, one, the maximum or anything in between, so every edge gets hit.
  function automatic logic [63:0] pick_count(int unsigned hi);
    case ($urandom_range(0, 3))
      0:       return 64'd0;
      1:       return 64'd1;
      2:       return 64'(hi);
      default: return 64'($urandom_range(0, hi));
    endcase
  endfunction

  function automatic logic [63:0] pick_length();
    return pick_count(3) * SZ_1G + pick_count(511) * SZ_2M + pick_count(511) * SZ_4K
           + 64'($urandom_range(0, 4095));
  endfunction

  // Mostly ranges laid around 2 MiB and 1 GiB boundaries, with some noise,
  // some ranges holding no whole frame and some at either end of the space.
  function automatic range_t pick_range();
    logic [63:0] s, e, base, off;
    range_t      r;
    case ($urandom_range(0, 9))
      0: begin
        s = rand_addr();
        e = rand_addr();
      end
      1: begin
        s = rand_addr();
        if ($urandom_range(0, 1) != 0) e = (s & ~64'hFFF) | 64'($urandom_range(0, 4095));
        else e = s >> $urandom_range(1, 40);
      end
      2: begin
        s = rand_addr();
        e = s + 64'($urandom_range(0, 1500)) * SZ_4K + 64'($urandom_range(0, 4095));
      end
      3: begin
        e = TOP_ADDR - pick_count(511) * SZ_4K;
        off = pick_length();
        s = (off > e) ? 64'd0 : e - off;
      end
      4: begin
        s = 64'($urandom_range(0, 4095));
        e = s + pick_length();
      end
      default: begin
        base = rand_addr() & ~(SZ_1G - 64'd1);
        if (base == 64'd0) base = SZ_1G;
        s = base - pick_count(511) * SZ_2M - pick_count(511) * SZ_4K
            + 64'($urandom_range(0, 4095));
        e = s + pick_length();
      end
    endcase
    if (e > TOP_ADDR) e = TOP_ADDR;
    r.base  = s[ADDR_W-1:0];
    r.limit = e[ADDR_W-1:0];
    return r;
  endfunction

  function automatic void queue_range(logic [63:0] s, logic [63:0] e);
    range_t r;
    r.base  = s[ADDR_W-1:0];
    r.limit = e[ADDR_W-1:0];
    ranges_to_send.push_back(r);
  endfunction

  function automatic void log_fault(string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
  endfunction

  // Writes the enable register over its own channel; only called while idle.
  task automatic write_enable(page_mask_t v);
    @(negedge clk);
    cfg_page_size_enable <= v;
    cfg_valid            <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    page_size_en = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Lets the sender run dry and every expected beat arrive, then waits out
  // the pipeline so the block is idle.
  task automatic drain_and_settle();
    int waited;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while ((ranges_to_send.size() != 0 || in_push || segs_due.size() != 0)
               && waited < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Input side: note accepted beats and predict their segments.
  always @(posedge clk) begin : take_ranges
    in_beat = rst_n && in_push && !in_full;
    if (rst_n && in_push && in_full) full_cycles++;
    if (in_beat) begin
      split_range(in_range_start, in_range_end, page_size_en);
      ranges_taken++;
    end
  end

  // Driver: offers the next pending range after a random gap.
  always @(negedge clk) begin : drive_ranges
    logic   push_nx;
    range_t nxt;
    push_nx = in_push;
    if (!rst_n) begin
      push_nx = 1'b0;
      tx_wait = 0;
    end else begin
      if (in_push && in_beat) begin
        push_nx = 1'b0;
        tx_wait = tx_calm ? 0 : $urandom_range(0, 7);
      end
      if (!push_nx) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (ranges_to_send.size() != 0) begin
          nxt = ranges_to_send.pop_front();
          in_range_start <= nxt.base;
          in_range_end   <= nxt.limit;
          push_nx = 1'b1;
        end
      end
    end
    in_push <= push_nx;
  end

  // Monitor: compares each segment beat with the oldest expectation.
  always @(posedge clk) begin : check_segs
    seg_rec_t want;
    out_beat = rst_n && out_pop && !out_empty;
    if (out_beat) begin
      segs_checked++;
      if (segs_due.size() == 0) begin
        log_fault($sformatf("unexpected segment: start %h end %h mask %0d empty %b last %b",
                            out_seg_start, out_seg_end, out_seg_page_mask,
                            out_seg_empty, out_seg_last));
      end else begin
        want = segs_due.pop_front();
        if (out_seg_start !== want.first || out_seg_end !== want.past ||
            out_seg_page_mask !== want.mask || out_seg_empty !== want.empty ||
            out_seg_last !== want.last) begin
          log_fault($sformatf({"segment mismatch: expected start %h end %h mask %0d ",
                               "empty %b last %b, got start %h end %h mask %0d ",
                               "empty %b last %b"},
                              want.first, want.past, want.mask, want.empty, want.last,
                              out_seg_start, out_seg_end, out_seg_page_mask,
                              out_seg_empty, out_seg_last));
        end
      end
    end
  end

  // Receiver: pops after a random stall, or holds off for a long stretch on request.
  always @(negedge clk) begin : drive_pop
    logic pop_nx;
    pop_nx = out_pop;
    if (!rst_n) begin
      pop_nx    = 1'b0;
      rx_wait   = 0;
      hold_left = 0;
    end else begin
      if (out_pop && out_beat) begin
        pop_nx  = 1'b0;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop_nx = 1'b0;
      end else if (!pop_nx) begin
        if (rx_wait > 0) rx_wait--;
        else pop_nx = 1'b1;
      end
    end
    out_pop <= pop_nx;
  end

  initial begin : run_phases
    int         ph;
    page_mask_t en;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed ranges with both large sizes enabled.
    write_enable(EN_BOTH);
    queue_range(64'd0, 64'd0);
    queue_range(TOP_ADDR, 64'd0);
    queue_range(TOP_ADDR, TOP_ADDR);
    queue_range(64'd0, TOP_ADDR);
    queue_range(64'hFFF, 64'h1FFF);
    queue_range(64'h1000, 64'h1FFF);
    queue_range(FIVE_BASE, FIVE_LIMIT);
    queue_range(SZ_2M + SZ_4K, SZ_2M + 9 * SZ_4K);
    queue_range(2 * SZ_2M, 5 * SZ_2M);
    queue_range(SZ_1G, 3 * SZ_1G);
    queue_range(SZ_2M - SZ_4K, 2 * SZ_2M + SZ_4K);
    queue_range(SZ_1G - SZ_4K, SZ_1G + SZ_4K);
    queue_range(TOP_ADDR - SZ_1G - 3 * SZ_2M, TOP_ADDR);
    queue_range(SZ_1G + 64'hFFF, 2 * SZ_1G);
    queue_range(SZ_2M, SZ_2M + 64'hFFF);
    queue_range(5 * SZ_1G, 5 * SZ_1G - SZ_4K);
    drain_and_settle();

    // Random phases, each under its own enable setting and idling pattern.
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0:       en = EN_NONE;
        1:       en = EN_2M;
        2:       en = EN_1G;
        default: en = EN_BOTH;
      endcase
      write_enable(en);
      tx_calm = (ph % 4 == 1);
      rx_calm = (ph % 4 == 1) || (ph == 6);
      queue_range(FIVE_BASE, FIVE_LIMIT);
      repeat (PHASE_RANGES) ranges_to_send.push_back(pick_range());
      // Stall the result side long enough for the block to back up.
      if (ph == 2) hold_req = 1'b1;
      drain_and_settle();
    end

    if (segs_due.size() != 0)
      log_fault($sformatf("%0d expected segments never arrived", segs_due.size()));

    $display("Run covered %0d ranges (%0d with no whole frame) giving %0d segment beats, %0d enable writes.",
             ranges_taken, empty_ranges, segs_checked, cfg_writes);
    $display("Ranges by segment count 1..5: %0d %0d %0d %0d %0d; input held off for %0d cycles.",
             seg_count_hist[1], seg_count_hist[2], seg_count_hist[3], seg_count_hist[4],
             seg_count_hist[5], full_cycles);
    if (err_count == 0) begin
      $display("huge_page_range_splitter_tb: done, clean");
    end else begin
      $display("huge_page_range_splitter_tb: done, errors");
    end
    $finish;
  end

  // Backstop in case the block hangs.
  initial begin : watchdog
    #2_000_000;
    $display("huge_page_range_splitter_tb: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/hprs_pkg.sv
hdl/hprs_front.sv
hdl/hprs_queue.sv
hdl/hprs_back.sv
hdl/huge_page_range_splitter.sv
dv/huge_page_range_splitter_tb.sv
